// ----- rtl/edfpn_pkg.sv -----
// ----------------------------------------------------------------------------
// Decay FIR / peak normaliser package
// Shared widths, codes, state encoding and the divider status bundle.
// ----------------------------------------------------------------------------
package edfpn_pkg;

   // Sizes
   localparam int unsigned TAPS        = 64;
   localparam int unsigned MAX_SAMPLES = 4096;

   // Field widths
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned RATIO_W  = 16;
   localparam int unsigned OP_W     = 2;

   // Derived widths
   localparam int unsigned TAP_W    = RATIO_W + 1;                 // Q1.16 coefficient
   localparam int unsigned TAP_AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int unsigned STORE_AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned MAC_W    = TAP_W + SAMPLE_W + 1;        // signed tap product
   localparam int unsigned ACC_W    = SAMPLE_W + RATIO_W + TAP_AW + 1;
   localparam int unsigned PEAK_W   = SAMPLE_W - 1;                // clamped input peak
   localparam int unsigned PROD_W   = ACC_W + PEAK_W;              // |sum| * input peak
   localparam int unsigned MUL_LO_W = (ACC_W + 1) / 2;
   localparam int unsigned MUL_HI_W = ACC_W - MUL_LO_W;
   localparam int unsigned QUO_W    = 16;
   localparam int unsigned QCNT_W   = $clog2(QUO_W + 1);

   // Constants
   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(58982);
   localparam logic [TAP_W-1:0]   TAP_ONE     = TAP_W'(1) << RATIO_W;
   localparam logic [PEAK_W-1:0]  PEAK_LIMIT  = '1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_FETCH = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_MAC,
      ST_LD_DRAIN,
      ST_FE_MAG,
      ST_FE_MUL_LO,
      ST_FE_MUL_HI,
      ST_FE_DIV_GO,
      ST_FE_DIV,
      ST_FE_EMIT
   } state_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_status_type;

endpackage

// ----- rtl/edfpn_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module edfpn_ram #(
   parameter  int unsigned WIDTH = 16,
   parameter  int unsigned DEPTH = 64,
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/edfpn_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned, one quotient bit per cycle; saturates when the quotient overflows.
// ----------------------------------------------------------------------------
module edfpn_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [edfpn_pkg::PROD_W-1:0]            dividend,
   input  logic [edfpn_pkg::ACC_W-1:0]             divisor,
   output edfpn_pkg::div_status_type               status
);

   localparam int unsigned DW = edfpn_pkg::ACC_W;
   localparam int unsigned QW = edfpn_pkg::QUO_W;
   localparam int unsigned HW = edfpn_pkg::PROD_W - edfpn_pkg::QUO_W;

   logic                          busy_ff;
   logic                          done_ff;
   logic [edfpn_pkg::QCNT_W-1:0]  cnt_ff;
   logic [DW-1:0]                 rem_ff;
   logic [QW-1:0]                 lo_ff;
   logic [QW-1:0]                 quo_ff;

   logic          ovf;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          take;

   // upper dividend bits already at or above divisor: quotient won't fit
   assign ovf   = {1'b0, dividend[edfpn_pkg::PROD_W-1:QW]} >= (HW+1)'(divisor);
   assign trial = {rem_ff, lo_ff[QW-1]};
   assign diff  = trial - {1'b0, divisor};
   assign take  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (ovf) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               cnt_ff  <= edfpn_pkg::QCNT_W'(QW);
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - edfpn_pkg::QCNT_W'(1);
            if (cnt_ff == edfpn_pkg::QCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DW'(dividend[edfpn_pkg::PROD_W-1:QW]);
         lo_ff  <= dividend[QW-1:0];
         quo_ff <= ovf ? '1 : '0;
      end else if (busy_ff) begin
         if (take) begin
            rem_ff <= diff[DW-1:0];
         end else begin
            rem_ff <= trial[DW-1:0];
         end
         lo_ff  <= {lo_ff[QW-2:0], 1'b0};
         quo_ff <= {quo_ff[QW-2:0], take};
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

// ----- rtl/exp_decay_fir_peak_normalizer.sv -----
// ----------------------------------------------------------------------------
// Exponential-decay FIR with peak normalisation
// Filters loaded samples, stores the sums, returns them scaled to input peak.
// ----------------------------------------------------------------------------
// Usage
//  req_*  : one item per transfer (req_valid high, req_stall low). req_op picks
//           load (sample into delay line, sum stored), fetch (one result) or
//           clear (empties counts, peaks and delay line; ratio kept).
//  rsp_*  : one result per fetch. none_left flags a fetch past the last sum.
//  csr_*  : decay_ratio write, Q0.16; only while the block is idle.
//  Flow   : a load does one multiply-accumulate per tap, each tap read from
//           the delay-line RAM, then drains the pipeline and writes the
//           store. A fetch scales the sum through the bit-serial divider;
//           with nothing left it skips to the result, with a zero output
//           peak it skips the multiply and divide. Clear, ignored ops and
//           loads into a full store return straight to idle. One item is worked on at a time.
//  Stall  : results sit in an output register; a new item is taken while one
//           waits. A fetch holds in its last state until the register frees.
//  Reset  : counts and peaks zero, decay_ratio 58982. Neither RAM is swept;
//           the fill count masks stale delay-line entries and stored sums are
//           only read below it.
// ----------------------------------------------------------------------------
module exp_decay_fir_peak_normalizer (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [edfpn_pkg::OP_W-1:0]             req_op,
   input  logic signed [edfpn_pkg::SAMPLE_W-1:0]  req_sample,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [edfpn_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output logic                                   rsp_last,
   output logic                                   rsp_none_left,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [edfpn_pkg::RATIO_W-1:0]          csr_wr_data
);

   localparam int unsigned SW = edfpn_pkg::SAMPLE_W;
   localparam int unsigned AW = edfpn_pkg::ACC_W;
   localparam int unsigned TA = edfpn_pkg::TAP_AW;
   localparam int unsigned CW = edfpn_pkg::CNT_W;

   // ---------------- state ----------------
   edfpn_pkg::state_type state_ff, state_in;

   logic [edfpn_pkg::RATIO_W-1:0] ratio_ff;
   logic [CW-1:0]                 cnt_ff;      // sums loaded since clear
   logic [CW-1:0]                 rp_ff;       // next sum to fetch
   logic [edfpn_pkg::PEAK_W-1:0]  ip_ff;       // input peak
   logic [AW-1:0]                 opeak_ff;    // output peak
   logic [TA-1:0]                 head_ff;     // newest delay-line slot
   logic [TA-1:0]                 idx_ff;      // tap being issued
   logic                          b_vld_ff;    // RAM data stage
   logic                          c_vld_ff;    // accumulate stage
   logic                          rsp_valid_ff;

   // datapath (no reset)
   logic signed [SW-1:0]             sample_ff;
   logic [edfpn_pkg::TAP_W-1:0]      tap_ff;
   logic [edfpn_pkg::TAP_W-1:0]      tap_b_ff;
   logic                             rd_vld_b_ff;
   logic signed [edfpn_pkg::MAC_W-1:0] prod_ff;
   logic signed [AW-1:0]             acc_ff;
   logic                             last_ff;
   logic                             neg_ff;
   logic [AW-1:0]                    mag_ff;
   logic [edfpn_pkg::MUL_LO_W+edfpn_pkg::PEAK_W-1:0] plo_ff;
   logic [edfpn_pkg::PROD_W-1:0]     dividend_ff;
   logic signed [SW-1:0]             res_sample_ff;
   logic                             res_last_ff;
   logic                             res_none_ff;
   logic signed [SW-1:0]             rsp_sample_ff;
   logic                             rsp_last_ff;
   logic                             rsp_none_ff;

   // ---------------- strobes ----------------
   logic accept;
   logic stall_c;
   logic dl_we;
   logic mac_issue;
   logic store_we;
   logic div_start;
   logic out_load;
   logic full;
   logic empty;

   // ---------------- RAM ports ----------------
   logic [TA-1:0]        dl_raddr;
   logic [TA:0]          dl_rsum;
   logic [SW-1:0]        dl_rdata;
   logic [AW-1:0]        st_rdata;

   edfpn_pkg::div_status_type div_st;

   assign full   = (cnt_ff == CW'(edfpn_pkg::MAX_SAMPLES));
   assign empty  = (rp_ff >= cnt_ff);
   assign accept = req_valid && !stall_c;

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edfpn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      stall_c   = 1'b1;
      dl_we     = 1'b0;
      mac_issue = 1'b0;
      store_we  = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         edfpn_pkg::ST_IDLE: begin
            stall_c = 1'b0;
            if (req_valid) begin
               case (req_op)
                  edfpn_pkg::OP_LOAD: begin
                     // full store: the load is taken and dropped
                     if (!full) begin
                        dl_we    = 1'b1;
                        state_in = edfpn_pkg::ST_LD_MAC;
                     end
                  end
                  edfpn_pkg::OP_FETCH: begin
                     state_in = empty ? edfpn_pkg::ST_FE_EMIT : edfpn_pkg::ST_FE_MAG;
                  end
                  default: begin
                     state_in = edfpn_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         edfpn_pkg::ST_LD_MAC: begin
            mac_issue = 1'b1;
            if (idx_ff == TA'(edfpn_pkg::TAPS - 1)) begin
               state_in = edfpn_pkg::ST_LD_DRAIN;
            end
         end
         edfpn_pkg::ST_LD_DRAIN: begin
            if (!b_vld_ff && !c_vld_ff) begin
               store_we = 1'b1;
               state_in = edfpn_pkg::ST_IDLE;
            end
         end
         edfpn_pkg::ST_FE_MAG: begin
            state_in = (opeak_ff == '0) ? edfpn_pkg::ST_FE_EMIT : edfpn_pkg::ST_FE_MUL_LO;
         end
         edfpn_pkg::ST_FE_MUL_LO: begin
            state_in = edfpn_pkg::ST_FE_MUL_HI;
         end
         edfpn_pkg::ST_FE_MUL_HI: begin
            state_in = edfpn_pkg::ST_FE_DIV_GO;
         end
         edfpn_pkg::ST_FE_DIV_GO: begin
            div_start = 1'b1;
            state_in  = edfpn_pkg::ST_FE_DIV;
         end
         edfpn_pkg::ST_FE_DIV: begin
            if (div_st.done) begin
               state_in = edfpn_pkg::ST_FE_EMIT;
            end
         end
         edfpn_pkg::ST_FE_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = edfpn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = edfpn_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = stall_c;

   // ---------------- delay line ----------------
   // circular buffer: tap i lives at head - i (mod TAPS); entries older than
   // the fill count read as zero
   always_comb begin
      if (head_ff >= idx_ff) begin
         dl_rsum = {1'b0, head_ff} - {1'b0, idx_ff};
      end else begin
         dl_rsum = {1'b0, head_ff} + (TA+1)'(edfpn_pkg::TAPS) - {1'b0, idx_ff};
      end
   end
   assign dl_raddr = dl_rsum[TA-1:0];

   edfpn_ram #(
      .WIDTH (SW),
      .DEPTH (edfpn_pkg::TAPS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (head_ff),
      .wr_data (req_sample),
      .rd_addr (dl_raddr),
      .rd_data (dl_rdata)
   );

   // ---------------- sum store ----------------
   edfpn_ram #(
      .WIDTH (AW),
      .DEPTH (edfpn_pkg::MAX_SAMPLES)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (cnt_ff[edfpn_pkg::STORE_AW-1:0]),
      .wr_data (acc_ff),
      .rd_addr (rp_ff[edfpn_pkg::STORE_AW-1:0]),
      .rd_data (st_rdata)
   );

   // ---------------- arithmetic ----------------
   logic [edfpn_pkg::TAP_W+edfpn_pkg::RATIO_W-1:0] tap_prod;
   logic [edfpn_pkg::TAP_W-1:0]                    tap_next;
   logic signed [SW-1:0]                           tap_data;
   logic signed [edfpn_pkg::MAC_W-1:0]             mac_prod;
   logic [SW-1:0]                                  in_abs;
   logic [edfpn_pkg::PEAK_W-1:0]                   mag_in;
   logic [AW-1:0]                                  acc_abs;
   logic [AW-1:0]                                  st_abs;
   logic [edfpn_pkg::MUL_LO_W+edfpn_pkg::PEAK_W-1:0] mul_lo;
   logic [edfpn_pkg::MUL_HI_W+edfpn_pkg::PEAK_W-1:0] mul_hi;
   logic [edfpn_pkg::PEAK_W-1:0]                   q_clamp;
   logic [SW-1:0]                                  q_ext;
   logic signed [SW-1:0]                           q_signed;

   // next coefficient: truncating Q1.16 x Q0.16
   assign tap_prod = tap_ff * ratio_ff;
   assign tap_next = tap_prod[edfpn_pkg::TAP_W+edfpn_pkg::RATIO_W-1:edfpn_pkg::RATIO_W];

   assign tap_data = rd_vld_b_ff ? $signed(dl_rdata) : '0;
   assign mac_prod = $signed({1'b0, tap_b_ff}) * tap_data;

   // input magnitude, most negative sample clamps to the limit
   assign in_abs = sample_ff[SW-1] ? (~sample_ff + SW'(1)) : sample_ff;
   assign mag_in = in_abs[SW-1] ? edfpn_pkg::PEAK_LIMIT : in_abs[edfpn_pkg::PEAK_W-1:0];

   assign acc_abs = acc_ff[AW-1] ? (~acc_ff + AW'(1)) : acc_ff;
   assign st_abs  = st_rdata[AW-1] ? (~st_rdata + AW'(1)) : st_rdata;

   // |sum| * input peak split in two partial products
   assign mul_lo = mag_ff[edfpn_pkg::MUL_LO_W-1:0] * ip_ff;
   assign mul_hi = mag_ff[AW-1:edfpn_pkg::MUL_LO_W] * ip_ff;

   assign q_clamp  = (div_st.quotient > edfpn_pkg::QUO_W'(edfpn_pkg::PEAK_LIMIT)) ?
                     edfpn_pkg::PEAK_LIMIT : div_st.quotient[edfpn_pkg::PEAK_W-1:0];
   assign q_ext    = {1'b0, q_clamp};
   assign q_signed = neg_ff ? $signed(SW'(0) - q_ext) : $signed(q_ext);

   edfpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend_ff),
      .divisor  (opeak_ff),
      .status   (div_st)
   );

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff     <= edfpn_pkg::RATIO_RESET;
         cnt_ff       <= '0;
         rp_ff        <= '0;
         ip_ff        <= '0;
         opeak_ff     <= '0;
         head_ff      <= '0;
         idx_ff       <= '0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ratio_ff <= csr_wr_data;
         end

         if (accept && req_op == edfpn_pkg::OP_CLEAR) begin
            cnt_ff   <= '0;
            rp_ff    <= '0;
            ip_ff    <= '0;
            opeak_ff <= '0;
            head_ff  <= '0;
         end

         if (accept && req_op == edfpn_pkg::OP_FETCH && !empty) begin
            rp_ff <= rp_ff + CW'(1);
         end

         if (dl_we) begin
            idx_ff <= '0;
         end else if (mac_issue) begin
            idx_ff <= idx_ff + TA'(1);
         end
         b_vld_ff <= mac_issue;
         c_vld_ff <= b_vld_ff;

         if (store_we) begin
            cnt_ff  <= cnt_ff + CW'(1);
            head_ff <= (head_ff == TA'(edfpn_pkg::TAPS - 1)) ? '0 : head_ff + TA'(1);
            if (mag_in > ip_ff) begin
               ip_ff <= mag_in;
            end
            if (acc_abs > opeak_ff) begin
               opeak_ff <= acc_abs;
            end
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      // load pipeline: issue -> RAM data -> product -> accumulate
      if (dl_we) begin
         sample_ff <= req_sample;
         tap_ff    <= edfpn_pkg::TAP_ONE;
         acc_ff    <= '0;
      end else if (c_vld_ff) begin
         acc_ff <= acc_ff + {{(AW-edfpn_pkg::MAC_W){prod_ff[edfpn_pkg::MAC_W-1]}}, prod_ff};
      end
      if (mac_issue) begin
         tap_ff      <= tap_next;
         tap_b_ff    <= tap_ff;
         rd_vld_b_ff <= (CW'(idx_ff) <= cnt_ff);
      end
      if (b_vld_ff) begin
         prod_ff <= mac_prod;
      end

      // fetch path
      if (accept && req_op == edfpn_pkg::OP_FETCH) begin
         last_ff <= ((rp_ff + CW'(1)) == cnt_ff);
         if (empty) begin
            res_sample_ff <= '0;
            res_last_ff   <= 1'b0;
            res_none_ff   <= 1'b1;
         end
      end
      if (state_ff == edfpn_pkg::ST_FE_MAG) begin
         neg_ff <= st_rdata[AW-1];
         mag_ff <= st_abs;
         // zero output peak: result is zero
         res_sample_ff <= '0;
         res_last_ff   <= last_ff;
         res_none_ff   <= 1'b0;
      end
      if (state_ff == edfpn_pkg::ST_FE_MUL_LO) begin
         plo_ff <= mul_lo;
      end
      if (state_ff == edfpn_pkg::ST_FE_MUL_HI) begin
         dividend_ff <= edfpn_pkg::PROD_W'(plo_ff)
                      + (edfpn_pkg::PROD_W'(mul_hi) << edfpn_pkg::MUL_LO_W);
      end
      if (state_ff == edfpn_pkg::ST_FE_DIV && div_st.done) begin
         res_sample_ff <= q_signed;
      end

      // output register
      if (out_load) begin
         rsp_sample_ff <= res_sample_ff;
         rsp_last_ff   <= res_last_ff;
         rsp_none_ff   <= res_none_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_none_left  = rsp_none_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(edfpn_pkg::MAX_SAMPLES))
      else $error("loaded count beyond store depth");

   a_rp_bound: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= cnt_ff)
      else $error("fetch pointer passed loaded count");

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (cnt_ff < CW'(edfpn_pkg::MAX_SAMPLES)))
      else $error("sum written into a full store");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == edfpn_pkg::ST_FE_DIV))
      else $error("divider finished outside the divide wait");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_none_left) |-> (rsp_sample_out == '0 && !rsp_last))
      else $error("empty fetch carries data");
`endif

endmodule
